// ===== rtl/core/distance_fitness_top_k_select_assert.svh =====
// Assertion macros for the checker of the top-k selection block.
// No dependencies.
`ifndef DISTANCE_FITNESS_TOP_K_SELECT_ASSERT_SVH
`define DISTANCE_FITNESS_TOP_K_SELECT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/dfs_pkg.sv =====
// Package for the top-k selection block: sizes, opcodes, register indexes, states.
// No dependencies.
package dfs_pkg;
	localparam int MAX_INDIVIDUALS = 64;
	localparam int MAX_DIMS        = 64;
	localparam int IND_W   = $clog2(MAX_INDIVIDUALS);
	localparam int DIM_W   = $clog2(MAX_DIMS);
	localparam int CNT_W   = IND_W + 1;
	localparam int DCNT_W  = DIM_W + 1;
	localparam int COORD_W = 24;
	localparam int FIT_W   = 48;
	localparam int SCORE_W = 56;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int SUM_W   = SQ_W + DIM_W + 1;
	localparam int CFG_W   = 7;

	typedef enum logic [1:0] {
		OP_LOAD_COORD = 2'd0,
		OP_LOAD_FIT   = 2'd1,
		OP_START      = 2'd2,
		OP_NONE       = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_DIMS   = 2'd0,
		REG_POP    = 2'd1,
		REG_PARENT = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_S_ADDR,   // issue coordinate reads for one gene
		ST_S_DIFF,   // register difference
		ST_S_MUL,    // square difference, accumulate
		ST_S_FIT,    // write score
		ST_K_INIT,
		ST_K_SCAN,   // scan score store for the best
		ST_K_LAST,   // last read data
		ST_OUT       // present result
	} state_t;
endpackage

// ===== rtl/core/distance_fitness_top_k_select.sv =====
// Top-k selection by distance-minus-fitness score, top level.
// Depends on dfs_pkg.
//
// Usage:
//  Input channel (valid/ready): one transaction carries an opcode. Load
//  coordinate and load fitness are written at the accepting edge and give no
//  result; ready stays high, so loads can follow back to back. A start
//  transaction scores every individual in use but the queen, then emits up to
//  num_parents best indices (fewer if fewer were scored), best first, ties broken toward the higher index;
//  the final result has last = 1.
//  Scoring uses one shared subtract/square/accumulate unit, one individual at
//  a time, and skips the queen. Selection starts with a setup step, then
//  scans the whole score store through one read port for each result.
//  Output channel (valid/ready): a result is held in the output register
//  until taken; a stalled receiver freezes the scan (no item is accepted
//  until the run ends). Configuration writes land at once; write them only
//  while idle.
//  Reset: control state and registers return to defaults (dims 10,
//  population 50, parents 25). Stores have no reset and need writing first.
module distance_fitness_top_k_select
	import dfs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               opcode,
	input  logic [5:0]               individual_index,
	input  logic [5:0]               gene_index,
	input  logic signed [COORD_W-1:0] coordinate,
	input  logic signed [FIT_W-1:0]  fitness_value,
	input  logic [5:0]               queen_index,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [5:0]               parent_index,
	output logic signed [SCORE_W-1:0] parent_score,
	output logic                     last
);
	// Configuration registers.
	logic [6:0] dims_q, pop_q;
	logic [5:0] npar_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 7'd10;
			pop_q  <= 7'd50;
			npar_q <= 6'd25;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMS:   dims_q <= cfg_data;
				REG_POP:    pop_q  <= cfg_data;
				REG_PARENT: npar_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Saturated working counts.
	logic [DCNT_W-1:0] dims_sat;
	logic [CNT_W-1:0]  pop_sat;
	assign dims_sat = (dims_q > 7'(MAX_DIMS)) ? DCNT_W'(MAX_DIMS) : DCNT_W'(dims_q);
	assign pop_sat  = (pop_q > 7'(MAX_INDIVIDUALS)) ? CNT_W'(MAX_INDIVIDUALS) : CNT_W'(pop_q);

	// Stores.
	logic signed [COORD_W-1:0] coord_mem [MAX_INDIVIDUALS*MAX_DIMS];
	logic signed [FIT_W-1:0]   fit_mem   [MAX_INDIVIDUALS];
	logic signed [SCORE_W-1:0] score_mem [MAX_INDIVIDUALS];

	state_t state_q, state_d;
	logic [IND_W-1:0]  queen_q;
	logic [CNT_W-1:0]  ind_q;        // individual being scored / scan pointer
	logic [DCNT_W-1:0] gene_q;
	logic [SUM_W-1:0]  acc_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [CNT_W-1:0]  cand_q;
	logic [5:0]        left_q;
	logic [MAX_INDIVIDUALS-1:0] taken_q;
	logic              have_q;
	logic [IND_W-1:0]  best_q;
	logic signed [SCORE_W-1:0] best_score_q;
	logic [CNT_W-1:0]  rd_idx_q;     // index of score read now returning
	logic              rd_ok_q;

	logic accept;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Results wanted this run: num_parents, saturated to the candidate count.
	logic [5:0] want_cnt;
	assign want_cnt = (CNT_W'(npar_q) > cand_q) ? 6'(cand_q) : npar_q;

	// Coordinate and fitness memory: one write port, registered reads.
	logic signed [COORD_W-1:0] ca_q, cb_q;
	logic signed [FIT_W-1:0]   fit_rd_q;
	logic [IND_W+DIM_W-1:0] wr_addr;
	assign wr_addr = {individual_index[IND_W-1:0], gene_index[DIM_W-1:0]};
	always_ff @(posedge clk) begin
		if (accept && opcode == OP_LOAD_COORD)
			coord_mem[wr_addr] <= coordinate;
		if (accept && opcode == OP_LOAD_FIT)
			fit_mem[individual_index[IND_W-1:0]] <= fitness_value;
		ca_q     <= coord_mem[{ind_q[IND_W-1:0], gene_q[DIM_W-1:0]}];
		cb_q     <= coord_mem[{queen_q, gene_q[DIM_W-1:0]}];
		fit_rd_q <= fit_mem[ind_q[IND_W-1:0]];
	end

	// Score store: one write in scoring, one registered read in scanning.
	logic signed [SCORE_W-1:0] score_rd_q;
	logic signed [SCORE_W-1:0] score_new;
	assign score_new = SCORE_W'(signed'({1'b0, acc_q[SUM_W-1:16]})) - SCORE_W'(fit_rd_q);
	always_ff @(posedge clk) begin
		if (state_q == ST_S_FIT)
			score_mem[ind_q[IND_W-1:0]] <= score_new;
		score_rd_q <= score_mem[ind_q[IND_W-1:0]];
	end

	// Shared unit: subtract, then square and accumulate.
	logic [SQ_W-1:0] sq;
	assign sq = SQ_W'(diff_q * diff_q);

	logic do_skip;   // current individual is the queen
	assign do_skip = (ind_q[IND_W-1:0] == queen_q) && (ind_q < pop_sat);

	// Compare the returning score against the best so far (ties go higher).
	logic better;
	assign better = rd_ok_q && !taken_q[rd_idx_q[IND_W-1:0]] &&
		(!have_q || score_rd_q >= best_score_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept && opcode == OP_START) state_d = ST_S_ADDR;
			ST_S_ADDR: begin
				if (ind_q == pop_sat) state_d = ST_K_INIT;
				else if (do_skip) state_d = ST_S_ADDR;
				else if (gene_q == dims_sat) state_d = ST_S_FIT;
				else state_d = ST_S_DIFF;
			end
			ST_S_DIFF: state_d = ST_S_MUL;
			ST_S_MUL:  state_d = ST_S_ADDR;
			ST_S_FIT:  state_d = ST_S_ADDR;
			ST_K_INIT: state_d = (want_cnt == 6'd0) ? ST_IDLE : ST_K_SCAN;
			ST_K_SCAN: if (ind_q == pop_sat) state_d = ST_K_LAST;
			ST_K_LAST: state_d = ST_OUT;
			ST_OUT:    if (out_ready) state_d = (left_q == 6'd1) ? ST_IDLE : ST_K_SCAN;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queen_q <= '0; ind_q <= '0; gene_q <= '0; acc_q <= '0; diff_q <= '0;
			cand_q <= '0; left_q <= '0; taken_q <= '0; have_q <= 1'b0;
			best_q <= '0; best_score_q <= '0; rd_idx_q <= '0; rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q  <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept && opcode == OP_START) begin
					queen_q <= queen_index[IND_W-1:0];
					ind_q <= '0; gene_q <= '0; acc_q <= '0; cand_q <= '0;
				end
				ST_S_ADDR: begin
					if (ind_q != pop_sat && do_skip) begin
						ind_q <= ind_q + 1'b1;
					end
				end
				ST_S_DIFF: diff_q <= DIFF_W'(ca_q) - DIFF_W'(cb_q);
				ST_S_MUL: begin
					acc_q  <= acc_q + SUM_W'(sq);
					gene_q <= gene_q + 1'b1;
				end
				ST_S_FIT: begin
					ind_q <= ind_q + 1'b1; gene_q <= '0; acc_q <= '0;
					cand_q <= cand_q + 1'b1;
				end
				ST_K_INIT: begin
					left_q <= want_cnt;
					// Mark the queen; a queen outside the population is never scanned.
					taken_q <= MAX_INDIVIDUALS'(1) << queen_q;
					ind_q <= '0; have_q <= 1'b0;
				end
				ST_K_SCAN: begin
					if (ind_q != pop_sat) begin
						rd_idx_q <= ind_q; rd_ok_q <= 1'b1;
						ind_q <= ind_q + 1'b1;
					end
					if (better) begin
						have_q <= 1'b1; best_q <= rd_idx_q[IND_W-1:0];
						best_score_q <= score_rd_q;
					end
				end
				ST_K_LAST: if (better) begin
					have_q <= 1'b1; best_q <= rd_idx_q[IND_W-1:0];
					best_score_q <= score_rd_q;
				end
				ST_OUT: if (out_ready) begin
					taken_q[best_q] <= 1'b1;
					left_q <= left_q - 1'b1;
					ind_q <= '0; have_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// The result is the best register pair while presented.
	assign out_valid    = (state_q == ST_OUT);
	assign parent_index = 6'(best_q);
	assign parent_score = best_score_q;
	assign last         = (left_q == 6'd1);
endmodule

// ===== rtl/core/dfs_checker.sv =====
// Port-level checker for the top-k selection block, bound to the top level.
// Depends on dfs_pkg and distance_fitness_top_k_select_assert.svh.
`include "distance_fitness_top_k_select_assert.svh"
module dfs_checker
	import dfs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [5:0] parent_index,
	input logic last
);
	// No new item while results are pending.
	`DFS_ASSERT_IMPL(a_busy, clk, arst_n, out_valid, !in_ready)
	// A stalled result holds its index.
	`DFS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, $stable(parent_index))
	// After the last transaction the block is not presenting again at once.
	`DFS_ASSERT_NEXT(a_end, clk, arst_n, out_valid && out_ready && last, !out_valid)
endmodule

bind distance_fitness_top_k_select dfs_checker u_dfs_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.parent_index(parent_index), .last(last)
);
